// ===== hdl/pidpd_pkg.sv =====
// ============================================================================
// PID controller shared package
// Types and constants used by the PID front end, term queue and back end.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package pidpd_pkg;

    // Gains and drive are 32-bit signed, limits are 31-bit magnitudes.
    localparam int GAIN_W     = 32;
    localparam int DRIVE_W    = 32;
    localparam int LIMIT_W    = 31;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    // A scaled gain product is saturated to +/-2^61, so 63 signed bits hold it.
    localparam int TERM_W = 63;
    localparam logic signed [TERM_W-1:0] TERM_LIMIT = 63'sh2000_0000_0000_0000;

    // Depth of the queue between the front end and the back end.
    localparam int QUEUE_DEPTH = 4;

    // Operating modes.
    localparam logic MODE_POSITIONAL  = 1'b0;
    localparam logic MODE_INCREMENTAL = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP             = 3'd0,
        REG_KI             = 3'd1,
        REG_KD             = 3'd2,
        REG_MODE           = 3'd3,
        REG_OUTPUT_LIMIT   = 3'd4,
        REG_INTEGRAL_LIMIT = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] ki;
        logic signed [GAIN_W-1:0] kd;
        logic                     mode;
        logic [LIMIT_W-1:0]       output_limit;
        logic [LIMIT_W-1:0]       integral_limit;
    } cfg_t;

    // Scaled and saturated P, I and D products of one sample.
    typedef struct packed {
        logic signed [TERM_W-1:0] p;
        logic signed [TERM_W-1:0] i;
        logic signed [TERM_W-1:0] d;
    } term_t;

endpackage : pidpd_pkg

`default_nettype wire

// ===== hdl/pidpd_ifs.sv =====
// ============================================================================
// PID controller channel interfaces
// Sample input, drive output and configuration write channels.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface pidpd_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] measured;
    logic signed [SAMPLE_BITS-1:0] target;

    modport source (output valid, output measured, output target, input ready);
    modport sink   (input valid, input measured, input target, output ready);
endinterface : pidpd_in_if

interface pidpd_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [pidpd_pkg::DRIVE_W-1:0]  drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface : pidpd_out_if

interface pidpd_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [pidpd_pkg::CFG_IDX_W-1:0]    index;
    logic [pidpd_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface : pidpd_cfg_if

`default_nettype wire

// ===== hdl/pidpd_front.sv =====
// ============================================================================
// PID front end
// Accepts samples, forms the error and its differences, and computes the
// three scaled gain products in a two-stage pipeline.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pidpd_front #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  pidpd_pkg::cfg_t      cfg,
    pidpd_in_if.sink             sample,
    output logic                 push_valid,
    input  wire logic            push_ready,
    output pidpd_pkg::term_t     push_data
);
    import pidpd_pkg::*;

    localparam int E_W    = SAMPLE_BITS + 1;
    localparam int OP_W   = SAMPLE_BITS + 3;
    localparam int PROD_W = GAIN_W + OP_W;
    localparam int EXT_W  = (PROD_W > 64) ? PROD_W : 64;

    // Stage A: error operands.
    logic                   a_valid_reg;
    logic signed [OP_W-1:0] a_p_op_reg;
    logic signed [E_W-1:0]  a_i_op_reg;
    logic signed [OP_W-1:0] a_d_op_reg;
    logic signed [E_W-1:0]  prev_err_reg;
    logic signed [E_W-1:0]  old_err_reg;

    // Stage B: scaled products.
    logic                   b_valid_reg;
    term_t                  b_term_reg;

    logic                   a_ready;
    logic                   b_ready;
    logic                   accept;
    logic signed [E_W-1:0]  err_now;
    logic signed [OP_W-1:0] diff1;
    logic signed [OP_W-1:0] diff2;
    logic signed [OP_W-1:0] p_op_next;
    logic signed [OP_W-1:0] d_op_next;
    logic signed [PROD_W-1:0] prod_p;
    logic signed [PROD_W-1:0] prod_i;
    logic signed [PROD_W-1:0] prod_d;
    term_t                  term_next;

    // Floor-scale a product and saturate it to +/-2^61.
    function automatic logic signed [TERM_W-1:0] scale_sat(
        input logic signed [PROD_W-1:0] prod
    );
        logic signed [PROD_W-1:0] shifted;
        logic signed [EXT_W-1:0]  v;
        logic signed [EXT_W-1:0]  lim;
        logic signed [TERM_W-1:0] neg_lim;
        shifted = prod >>> FRAC_BITS;
        v       = EXT_W'(shifted);
        lim     = EXT_W'(TERM_LIMIT);
        neg_lim = -TERM_LIMIT;
        if (v > lim) begin
            return TERM_LIMIT;
        end
        else if (v < -lim) begin
            return neg_lim;
        end
        else begin
            return v[TERM_W-1:0];
        end
    endfunction

    assign b_ready      = !b_valid_reg || push_ready;
    assign a_ready      = !a_valid_reg || b_ready;
    assign sample.ready = a_ready;
    assign accept       = sample.valid && a_ready;

    always_comb
    begin
        err_now = E_W'(sample.target) - E_W'(sample.measured);
        diff1   = OP_W'(err_now) - OP_W'(prev_err_reg);
        diff2   = OP_W'(err_now) - (OP_W'(prev_err_reg) <<< 1) + OP_W'(old_err_reg);
        if (cfg.mode == MODE_INCREMENTAL) begin
            p_op_next = diff1;
            d_op_next = diff2;
        end
        else begin
            p_op_next = OP_W'(err_now);
            d_op_next = diff1;
        end
    end

    always_comb
    begin
        prod_p      = a_p_op_reg * cfg.kp;
        prod_i      = a_i_op_reg * cfg.ki;
        prod_d      = a_d_op_reg * cfg.kd;
        term_next.p = scale_sat(prod_p);
        term_next.i = scale_sat(prod_i);
        term_next.d = scale_sat(prod_d);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            prev_err_reg <= '0;
            old_err_reg  <= '0;
        end
        else begin
            if (a_ready) begin
                a_valid_reg <= sample.valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
            if (accept) begin
                old_err_reg  <= prev_err_reg;
                prev_err_reg <= err_now;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            a_p_op_reg <= p_op_next;
            a_i_op_reg <= err_now;
            a_d_op_reg <= d_op_next;
        end
        if (b_ready && a_valid_reg) begin
            b_term_reg <= term_next;
        end
    end

    assign push_valid = b_valid_reg;
    assign push_data  = b_term_reg;

endmodule : pidpd_front

`default_nettype wire

// ===== hdl/pidpd_fifo.sv =====
// ============================================================================
// PID term queue
// Small register queue that decouples the front end from the back end.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pidpd_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push_valid,
    output logic                 push_ready,
    input  pidpd_pkg::term_t     push_data,
    output logic                 pop_valid,
    input  wire logic            pop_ready,
    output pidpd_pkg::term_t     pop_data
);
    import pidpd_pkg::*;

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    term_t             slot_reg [DEPTH];
    logic [ADDR_W-1:0] wr_ptr_reg;
    logic [ADDR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    logic push;
    logic pop;

    function automatic logic [ADDR_W-1:0] bump(input logic [ADDR_W-1:0] ptr);
        if (ptr == ADDR_W'(DEPTH - 1)) begin
            return '0;
        end
        else begin
            return ptr + 1'b1;
        end
    endfunction

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (push) begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // An empty queue has both pointers on the same slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue empty but pointers differ");

    // The fill count never passes the depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule : pidpd_fifo

`default_nettype wire

// ===== hdl/pidpd_back.sv =====
// ============================================================================
// PID back end
// Runs the integral and held-output loops, applies the limits and holds the
// drive word in the output register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pidpd_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  pidpd_pkg::cfg_t      cfg,
    input  wire logic            pop_valid,
    output logic                 pop_ready,
    input  pidpd_pkg::term_t     pop_data,
    pidpd_out_if.source          result
);
    import pidpd_pkg::*;

    localparam int SUM_W = TERM_W + 3;

    logic                      s1_valid_reg;
    logic signed [SUM_W-1:0]   s1_pd_reg;
    logic signed [DRIVE_W-1:0] s1_i_reg;
    logic signed [DRIVE_W-1:0] integral_reg;
    logic signed [DRIVE_W-1:0] held_reg;
    logic                      out_valid_reg;
    logic signed [DRIVE_W-1:0] drive_reg;

    logic                      s1_ready;
    logic                      s2_ready;
    logic                      s1_fire;
    logic                      s2_fire;
    logic signed [SUM_W-1:0]   i_sum;
    logic signed [DRIVE_W-1:0] integral_next;
    logic signed [SUM_W-1:0]   pd_sum;
    logic signed [SUM_W-1:0]   out_sum;
    logic signed [DRIVE_W-1:0] drive_next;

    // Symmetric magnitude clamp; a zero limit gives zero.
    function automatic logic signed [DRIVE_W-1:0] clamp_mag(
        input logic signed [SUM_W-1:0] v,
        input logic [LIMIT_W-1:0]      lim
    );
        logic signed [SUM_W-1:0] pos_lim;
        logic signed [SUM_W-1:0] neg_lim;
        pos_lim = SUM_W'({1'b0, lim});
        neg_lim = -pos_lim;
        if (v > pos_lim) begin
            return pos_lim[DRIVE_W-1:0];
        end
        else if (v < neg_lim) begin
            return neg_lim[DRIVE_W-1:0];
        end
        else begin
            return v[DRIVE_W-1:0];
        end
    endfunction

    assign s2_ready  = !out_valid_reg || result.ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign pop_ready = s1_ready;
    assign s1_fire   = pop_valid && s1_ready;
    assign s2_fire   = s1_valid_reg && s2_ready;

    always_comb
    begin
        if (cfg.mode == MODE_INCREMENTAL) begin
            i_sum = SUM_W'(pop_data.i);
        end
        else begin
            i_sum = SUM_W'(integral_reg) + SUM_W'(pop_data.i);
        end
        integral_next = clamp_mag(i_sum, cfg.integral_limit);
        pd_sum        = SUM_W'(pop_data.p) + SUM_W'(pop_data.d);
    end

    always_comb
    begin
        out_sum = s1_pd_reg + SUM_W'(s1_i_reg);
        if (cfg.mode == MODE_INCREMENTAL) begin
            out_sum = out_sum + SUM_W'(held_reg);
        end
        drive_next = clamp_mag(out_sum, cfg.output_limit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            integral_reg  <= '0;
            held_reg      <= '0;
        end
        else begin
            if (s1_ready) begin
                s1_valid_reg <= pop_valid;
            end
            if (s2_ready) begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s1_fire) begin
                integral_reg <= integral_next;
            end
            if (s2_fire && (cfg.mode == MODE_INCREMENTAL)) begin
                held_reg <= drive_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire) begin
            s1_pd_reg <= pd_sum;
            s1_i_reg  <= integral_next;
        end
        if (s2_fire) begin
            drive_reg <= drive_next;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.drive = drive_reg;

    // In incremental mode the word on offer is the held output itself.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (cfg.mode == MODE_INCREMENTAL)) |-> (result.drive == held_reg))
        else $error("incremental drive differs from held output");

    // Every drive word on offer lies within the output limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> ((result.drive <= $signed({1'b0, cfg.output_limit}))
                       && (result.drive >= -$signed({1'b0, cfg.output_limit}))))
        else $error("drive outside output limit");

endmodule : pidpd_back

`default_nettype wire

// ===== hdl/pid_position_delta_controller.sv =====
// ============================================================================
// PID position/delta controller
// One PID step per sample word: positional (P+I+D) or incremental (delta) mode.
//
// Channels: sample carries a measured/target word in, result carries one
// drive word out for every sample, cfg writes the gain, mode and limit
// registers (index 0 kp, 1 ki, 2 kd, 3 mode, 4 output_limit, 5 integral_limit).
// cfg is always ready; write it only while no sample is in flight.
// Throughput: one sample word per clock while nothing stalls. The front end
// takes a word whenever its two-stage product pipeline can advance; the back
// end closes the integral and held-output loops in one add-and-clamp step each.
// Path: the drive word passes the operand stage, product stage, queue, loop
// stage and output register in turn.
// Stalls: a stalled result holds in the output register while the loop stage
// and the four-entry term queue keep filling; sample.ready drops only once
// the queue and both front stages are full.
// Reset: the configuration, error history, integral term and held output clear
// to zero, and the pipeline empties; no clearing pass is needed.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pid_position_delta_controller #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    pidpd_in_if.sink    sample,
    pidpd_out_if.source result,
    pidpd_cfg_if.sink   cfg
);
    import pidpd_pkg::*;

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    logic  push_valid;
    logic  push_ready;
    term_t push_data;
    logic  pop_valid;
    logic  pop_ready;
    term_t pop_data;

    // Configuration writes are always taken; unknown indexes are dropped.
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid) begin
            unique case (cfg_idx_t'(cfg.index))
                REG_KP:             cfg_next.kp             = cfg.data;
                REG_KI:             cfg_next.ki             = cfg.data;
                REG_KD:             cfg_next.kd             = cfg.data;
                REG_MODE:           cfg_next.mode           = cfg.data[0];
                REG_OUTPUT_LIMIT:   cfg_next.output_limit   = cfg.data[LIMIT_W-1:0];
                REG_INTEGRAL_LIMIT: cfg_next.integral_limit = cfg.data[LIMIT_W-1:0];
                default:            cfg_next                = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg <= '0;
        end
        else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: error, differences and scaled gain products.
    pidpd_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .sample     (sample),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Term queue between the two halves.
    pidpd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Back end: integral and held-output loops, clamps and output register.
    pidpd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .result    (result)
    );

endmodule : pid_position_delta_controller

`default_nettype wire
